### rtl/core/deu_pkg.sv
// deu_pkg: shared types, constants and the coefficient ROM of the double exp unit.
// Used by deu_fpu and double_exp_unit_core. No dependencies.
`timescale 1ns / 1ps

package deu_pkg;

  // Horner term count and coefficient table size
  localparam int NUM_TERMS_DEF = 19;
  localparam int COEF_COUNT    = 19;
  localparam int COEF_IDX_W    = 5;

  // Internal arithmetic widths
  localparam int SIG_W  = 53;          // significand with hidden bit
  localparam int NORM_W = 2 * SIG_W;   // widest unrounded significand (product)
  localparam int EXP_W  = 14;          // signed internal exponent

  // binary64 field constants
  localparam int EXP_BIAS      = 1023;
  localparam int FRAC_W        = 52;
  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;

  // Scale factor saturation: beyond these p * 2^n is surely inf or +0
  localparam int SCALE_MAX = 2100;
  localparam int SCALE_MIN = -2200;

  // Double constants
  localparam logic [63:0] LOG2E_BITS = $realtobits(1.4426950408889633870E0);
  localparam logic [63:0] LN2_BITS   = $realtobits(6.9314718055994530942705877E-1);
  localparam logic [63:0] ONE_BITS   = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] HALF_BITS  = 64'h3FE0_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT  = 64'h0008_0000_0000_0000;

  // Taylor coefficients, ascending order
  localparam logic [63:0] COEF_ROM [COEF_COUNT] = '{
    $realtobits(1.0000000000000000000E0),
    $realtobits(1.0000000000000000000E0),
    $realtobits(0.5000000000000000000E0),
    $realtobits(0.1666666666666666667E0),
    $realtobits(0.0416666666666666667E0),
    $realtobits(0.0083333333333333333E0),
    $realtobits(0.0013888888888888889E0),
    $realtobits(1.9841269841269841270E-4),
    $realtobits(2.4801587301587301587E-5),
    $realtobits(2.7557319223985894396E-6),
    $realtobits(2.7557319223985894396E-7),
    $realtobits(2.5052108385441722582E-8),
    $realtobits(2.0876756987868101412E-9),
    $realtobits(1.6059043836821618179E-10),
    $realtobits(1.1470745597729725684E-11),
    $realtobits(7.6471637318198171229E-13),
    $realtobits(4.7794773323873860349E-14),
    $realtobits(2.8114572543455219389E-15),
    $realtobits(1.5619206968586232698E-16)
  };

  function automatic logic [63:0] coef_bits(input logic [COEF_IDX_W-1:0] idx);
    logic [63:0] v;
    v = 64'h0;
    if (idx < COEF_IDX_W'(COEF_COUNT)) v = COEF_ROM[idx];
    return v;
  endfunction

  // Operations of the shared float unit
  typedef enum logic [1:0] {
    FOP_MUL,
    FOP_ADD,
    FOP_SCALE
  } fop_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_ALIGN,
    F_ADD,
    F_NORM,
    F_SHR,
    F_ROUND
  } fpu_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_X,
    S_SPLIT,
    S_SUB_FR,
    S_CHECK,
    S_ADJ_IP,
    S_ADJ_FR,
    S_TO_INT,
    S_MUL_Z,
    S_H_MUL,
    S_H_ADD,
    S_SCALE,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic                    start;
    fop_t                    op;
    logic [63:0]             a;
    logic [63:0]             b;
    logic signed [EXP_W-1:0] n;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fpu_rsp_t;

endpackage

### rtl/core/deu_fpu.sv
// deu_fpu: shared binary64 multiply / add / scale-by-2^n unit, round to nearest even.
// Multi-cycle, one operation at a time. Depends on deu_pkg.
`timescale 1ns / 1ps

module deu_fpu
  import deu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  fpu_req_t req,
  output fpu_rsp_t rsp
);

  localparam int LZ_W     = $clog2(NORM_W + 1);
  localparam int D_W      = $clog2(NORM_W + 2);
  localparam int HALF_W   = (SIG_W + 1) / 2;
  localparam int ALN_W    = SIG_W + 3;            // significand plus guard, round, sticky
  localparam int ALN_IDX  = $clog2(ALN_W);
  localparam int MUL_OFS  = 2 * (EXP_BIAS + FRAC_W);
  localparam int ONE_OFS  = EXP_BIAS + FRAC_W;
  localparam int ADD_OFS  = EXP_BIAS + FRAC_W + 3;
  localparam int SUB_EXP  = EXP_BIAS + FRAC_W - 1; // 1074

  function automatic logic [SIG_W-1:0] sig_of(input logic [63:0] v);
    return {(v[62:52] != 11'h0), v[51:0]};
  endfunction

  function automatic logic signed [EXP_W-1:0] exp_of(input logic [63:0] v);
    return (v[62:52] == 11'h0) ? EXP_W'(1) : EXP_W'({1'b0, v[62:52]});
  endfunction

  fpu_state_t state, state_next;

  logic                    sgn, zsgn, inf_flag, sub;
  logic signed [EXP_W-1:0] ex, exa, exb, q;
  logic [NORM_W-1:0]       acc;
  logic [SIG_W-1:0]        ma, mb, kept;
  logic                    sa, sb, rnd, stk;
  logic [ALN_W-1:0]        big_al, small_al;
  logic [1:0]              pp_cnt;
  logic [63:0]             res;
  logic                    done;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (req.start) begin
          unique case (req.op)
            FOP_MUL:   state_next = F_MUL;
            FOP_ADD:   state_next = F_ALIGN;
            FOP_SCALE: state_next = F_NORM;
            default:   state_next = F_IDLE;
          endcase
        end
      end
      F_MUL:   if (pp_cnt == 2'd3) state_next = F_NORM;
      F_ALIGN: state_next = F_ADD;
      F_ADD:   state_next = F_NORM;
      F_NORM:  state_next = F_SHR;
      F_SHR:   state_next = F_ROUND;
      F_ROUND: state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // one 27x27 partial product per cycle
  logic [HALF_W-1:0]   pa, pb;
  logic [2*HALF_W-1:0] pprod;
  logic [NORM_W-1:0]   pp_sh;
  always_comb begin
    pa    = pp_cnt[1] ? HALF_W'(ma >> HALF_W) : ma[HALF_W-1:0];
    pb    = pp_cnt[0] ? HALF_W'(mb >> HALF_W) : mb[HALF_W-1:0];
    pprod = pa * pb;
    pp_sh = (NORM_W'(pprod) << (pp_cnt[1] ? HALF_W : 0)) << (pp_cnt[0] ? HALF_W : 0);
  end

  // alignment of the smaller addend, sticky folded into the lsb
  logic                    a_ge;
  logic [SIG_W-1:0]        big_sig, small_sig;
  logic signed [EXP_W-1:0] big_exp, diff;
  logic [ALN_W-1:0]        small_ext, small_sh, lost_mask;
  always_comb begin
    a_ge      = (exa > exb) || ((exa == exb) && (ma >= mb));
    big_sig   = a_ge ? ma : mb;
    small_sig = a_ge ? mb : ma;
    big_exp   = a_ge ? exa : exb;
    diff      = a_ge ? (exa - exb) : (exb - exa);
    small_ext = {small_sig, 3'b000};
    lost_mask = '0;
    small_sh  = '0;
    if (diff >= EXP_W'(ALN_W)) begin
      small_sh = ALN_W'(small_sig != '0);
    end else begin
      lost_mask = (ALN_W'(1) << diff[ALN_IDX-1:0]) - ALN_W'(1);
      small_sh  = (small_ext >> diff[ALN_IDX-1:0])
                | ALN_W'((small_ext & lost_mask) != '0);
    end
  end

  // add or subtract magnitudes
  logic [ALN_W:0] sum;
  always_comb begin
    if (sub) sum = {1'b0, big_al} - {1'b0, small_al};
    else     sum = {1'b0, big_al} + {1'b0, small_al};
  end

  // leading zero count
  logic [LZ_W-1:0] lz;
  always_comb begin
    lz = LZ_W'(NORM_W);
    for (int i = 0; i < NORM_W; i++) begin
      if (acc[i]) lz = LZ_W'(NORM_W - 1 - i);
    end
  end

  // drop count: normal needs 53 kept bits, subnormal stops at 2^-1074
  logic signed [EXP_W:0]  dmin;
  logic [D_W-1:0]         d;
  logic [2*NORM_W-1:0]    wide;
  always_comb begin
    dmin = $signed((EXP_W+1)'(-SUB_EXP)) - $signed({ex[EXP_W-1], ex});
    if (dmin > $signed((EXP_W+1)'(NORM_W + 1)))
      d = D_W'(NORM_W + 1);
    else if (dmin > $signed((EXP_W+1)'(NORM_W - SIG_W)))
      d = D_W'(dmin);
    else
      d = D_W'(NORM_W - SIG_W);
    wide = {acc, NORM_W'(0)} >> d;
  end

  // round to nearest even and pack
  logic                    inc;
  logic [SIG_W:0]          m;
  logic [SIG_W-1:0]        mant;
  logic signed [EXP_W-1:0] qq, be;
  logic [63:0]             packed_res;
  always_comb begin
    inc = rnd & (stk | kept[0]);
    m   = {1'b0, kept} + (SIG_W+1)'(inc);
    if (m[SIG_W]) begin
      mant = m[SIG_W:1];
      qq   = q + EXP_W'(1);
    end else begin
      mant = m[SIG_W-1:0];
      qq   = q;
    end
    be = mant[SIG_W-1] ? (qq + EXP_W'(ONE_OFS)) : EXP_W'(0);
    if (inf_flag || (be >= EXP_W'(2047)))
      packed_res = {sgn, EXP_ALL_ONES, 52'h0};
    else
      packed_res = {sgn, be[10:0], mant[FRAC_W-1:0]};
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        sa       <= req.a[63];
        sb       <= req.b[63];
        ma       <= sig_of(req.a);
        mb       <= sig_of(req.b);
        exa      <= exp_of(req.a);
        exb      <= exp_of(req.b);
        pp_cnt   <= 2'd0;
        if (req.op == FOP_MUL) begin
          sgn      <= req.a[63] ^ req.b[63];
          inf_flag <= (req.a[62:52] == EXP_ALL_ONES) || (req.b[62:52] == EXP_ALL_ONES);
          acc      <= '0;
          ex       <= exp_of(req.a) + exp_of(req.b) - EXP_W'(MUL_OFS);
        end else if (req.op == FOP_SCALE) begin
          sgn      <= req.a[63];
          inf_flag <= 1'b0;
          acc      <= NORM_W'(sig_of(req.a));
          ex       <= exp_of(req.a) - EXP_W'(ONE_OFS) + req.n;
        end else begin
          sgn      <= req.a[63];
          inf_flag <= 1'b0;
          acc      <= '0;
        end
      end
      F_MUL: begin
        acc    <= acc + pp_sh;
        pp_cnt <= pp_cnt + 2'd1;
      end
      F_ALIGN: begin
        big_al   <= {big_sig, 3'b000};
        small_al <= small_sh;
        sub      <= sa ^ sb;
        sgn      <= a_ge ? sa : sb;
        zsgn     <= sa & sb;
        ex       <= big_exp - EXP_W'(ADD_OFS);
      end
      F_ADD: begin
        acc <= NORM_W'(sum);
        if (sum == '0) sgn <= zsgn;
      end
      F_NORM: begin
        acc <= acc << lz;
        ex  <= ex - EXP_W'(lz);
      end
      F_SHR: begin
        kept <= wide[NORM_W+SIG_W-1:NORM_W];
        rnd  <= wide[NORM_W-1];
        stk  <= (wide[NORM_W-2:0] != '0);
        q    <= ex + $signed(EXP_W'(d));
      end
      F_ROUND: res <= packed_res;
      default: ;
    endcase
  end

  // completion pulse
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= (state == F_ROUND);
  end

  assign rsp.done = done;
  assign rsp.res  = res;

endmodule

### rtl/core/double_exp_unit_core.sv
// double_exp_unit_core: e^x for one binary64 word, range reduction plus Horner Taylor series.
// A NaN word skips the series and goes straight to the output as a quiet NaN; every other word runs
// its multiplies, adds and the final scale one at a time on deu_fpu.
// The input stalls while a word is in work; a finished result waits in the output register.
// Reset (rst, synchronous): sequencer idle, output empty. Depends on deu_pkg, deu_fpu.
`timescale 1ns / 1ps

module double_exp_unit_core
  import deu_pkg::*;
#(
  parameter int NUM_TERMS = NUM_TERMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] x_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_bits
);

  localparam int KW      = (NUM_TERMS > 2) ? $clog2(NUM_TERMS) : 1;
  localparam int SAT_EXP = EXP_BIAS + 12;   // |ip| >= 4096 saturates n
  localparam int MAG_W   = 12;

  seq_state_t state, state_next;

  fpu_req_t req;
  fpu_rsp_t rsp;

  logic [63:0]             xr, y, ip, fr, z, r, res;
  logic                    adj_neg, issued;
  logic signed [EXP_W-1:0] n_val;
  logic [KW-1:0]           k;
  logic                    load_out;

  deu_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // split helpers
  logic [10:0] ye, ie;
  logic [51:0] ymask;
  logic        x_nan, fr_big;
  always_comb begin
    ye     = y[62:52];
    ie     = ip[62:52];
    ymask  = 52'hF_FFFF_FFFF_FFFF >> 6'(ye - 11'(EXP_BIAS));
    x_nan  = (x_bits[62:52] == EXP_ALL_ONES) && (x_bits[51:0] != 52'h0);
    fr_big = (fr[62:0] > HALF_BITS[62:0]);
  end

  // next state and float unit request
  always_comb begin
    state_next = state;
    req.start  = 1'b0;
    req.op     = FOP_ADD;
    req.a      = r;
    req.b      = z;
    req.n      = n_val;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = x_nan ? S_OUT : S_MUL_X;
      end
      S_MUL_X: begin
        req.op = FOP_MUL;
        req.a  = xr;
        req.b  = LOG2E_BITS;
        if (rsp.done) state_next = S_SPLIT;
      end
      S_SPLIT: begin
        if ((ye >= 11'(EXP_BIAS + FRAC_W)) || (ye < 11'(EXP_BIAS))) state_next = S_CHECK;
        else state_next = S_SUB_FR;
      end
      S_SUB_FR: begin
        req.a = y;
        req.b = {~ip[63], ip[62:0]};
        if (rsp.done) state_next = S_CHECK;
      end
      S_CHECK: state_next = fr_big ? S_ADJ_IP : S_TO_INT;
      S_ADJ_IP: begin
        req.a = ip;
        req.b = {adj_neg, ONE_BITS[62:0]};
        if (rsp.done) state_next = S_ADJ_FR;
      end
      S_ADJ_FR: begin
        req.a = fr;
        req.b = {~adj_neg, ONE_BITS[62:0]};
        if (rsp.done) state_next = S_TO_INT;
      end
      S_TO_INT: state_next = S_MUL_Z;
      S_MUL_Z: begin
        req.op = FOP_MUL;
        req.a  = fr;
        req.b  = LN2_BITS;
        if (rsp.done) state_next = S_H_MUL;
      end
      S_H_MUL: begin
        req.op = FOP_MUL;
        if (rsp.done) state_next = S_H_ADD;
      end
      S_H_ADD: begin
        req.b = coef_bits(COEF_IDX_W'(k));
        if (rsp.done) state_next = (k == '0) ? S_SCALE : S_H_MUL;
      end
      S_SCALE: begin
        req.op = FOP_SCALE;
        if (rsp.done) state_next = S_OUT;
      end
      S_OUT: if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    req.start = !issued && (state == S_MUL_X || state == S_SUB_FR || state == S_ADJ_IP ||
                            state == S_ADJ_FR || state == S_MUL_Z || state == S_H_MUL ||
                            state == S_H_ADD || state == S_SCALE);
  end

  assign in_stall = (state != S_IDLE);
  assign load_out = (state == S_OUT) && (!out_valid || !out_stall);

  // one float operation in flight
  always_ff @(posedge clk) begin
    if (rst)           issued <= 1'b0;
    else if (rsp.done) issued <= 1'b0;
    else if (req.start) issued <= 1'b1;
  end

  // integer part to a saturated scale count
  logic [SIG_W-1:0]        ip_sh;
  logic [MAG_W-1:0]        mag;
  logic signed [EXP_W-1:0] n_conv;
  always_comb begin
    ip_sh = {1'b1, ip[51:0]} >> 6'(11'(EXP_BIAS + FRAC_W) - ie);
    mag   = ip_sh[MAG_W-1:0];
    if (ie < 11'(EXP_BIAS))
      n_conv = '0;
    else if (ie >= 11'(SAT_EXP))
      n_conv = ip[63] ? EXP_W'(SCALE_MIN) : EXP_W'(SCALE_MAX);
    else if (ip[63])
      n_conv = -$signed(EXP_W'(mag));
    else
      n_conv = $signed(EXP_W'(mag));
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        xr  <= x_bits;
        res <= x_bits | QUIET_BIT;
      end
      S_MUL_X:  if (rsp.done) y <= rsp.res;
      S_SPLIT: begin
        if (ye >= 11'(EXP_BIAS + FRAC_W)) begin
          ip <= y;
          fr <= {y[63], 63'h0};
        end else if (ye < 11'(EXP_BIAS)) begin
          ip <= {y[63], 63'h0};
          fr <= y;
        end else begin
          ip <= {y[63:52], y[51:0] & ~ymask};
        end
      end
      S_SUB_FR: if (rsp.done) fr <= rsp.res;
      S_CHECK:  adj_neg <= fr[63];
      S_ADJ_IP: if (rsp.done) ip <= rsp.res;
      S_ADJ_FR: if (rsp.done) fr <= rsp.res;
      S_TO_INT: n_val <= n_conv;
      S_MUL_Z: begin
        if (rsp.done) begin
          z <= rsp.res;
          r <= coef_bits(COEF_IDX_W'(NUM_TERMS - 1));
          k <= KW'(NUM_TERMS - 1);
        end
      end
      S_H_MUL: begin
        if (rsp.done) begin
          r <= rsp.res;
          k <= k - KW'(1);
        end
      end
      S_H_ADD:  if (rsp.done) r <= rsp.res;
      S_SCALE:  if (rsp.done) res <= rsp.res;
      S_OUT:    ;
      default:  ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst)             out_valid <= 1'b0;
    else if (load_out)   out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) result_bits <= res;
  end

endmodule

### sim/tb_top.sv
// tb_top: self-checking testbench of double_exp_unit_core (e^x on binary64 words).
// Needs deu_pkg for the coefficient ROM and the log2(e) / ln2 constants.
`timescale 1ns / 1ps

module tb_top;
  import deu_pkg::*;

  localparam int  RAND_WORDS  = 1230;
  localparam int  DRAIN_CYC   = 400;
  localparam longint CYC_LIMIT = 3_000_000;
  localparam logic [63:0] POS_ONE = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] POS_ZERO = 64'h0;

  typedef struct {
    logic [63:0] x;
    bit          fixed;   // result typed in below, else taken from exp_predict
    logic [63:0] res;
  } exp_row_t;

  localparam int DIR_ROWS = 22;
  exp_row_t dir_tab [DIR_ROWS] = '{
    '{64'h0000_0000_0000_0000, 1'b1, POS_ONE},
    '{64'h8000_0000_0000_0000, 1'b1, POS_ONE},
    '{64'h7FF0_0000_0000_0000, 1'b1, POS_INF},
    '{64'hFFF0_0000_0000_0000, 1'b1, POS_ZERO},
    '{64'h7FF0_0000_0000_0001, 1'b1, 64'h7FF8_0000_0000_0001},
    '{64'hFFF0_0000_0000_0001, 1'b1, 64'hFFF8_0000_0000_0001},
    '{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF},
    '{64'h7FEF_FFFF_FFFF_FFFF, 1'b1, POS_INF},
    '{64'hFFEF_FFFF_FFFF_FFFF, 1'b1, POS_ZERO},
    '{64'h7E37_E43C_8800_759C, 1'b1, POS_INF},
    '{64'hFE37_E43C_8800_759C, 1'b1, POS_ZERO},
    '{64'h0000_0000_0000_0001, 1'b1, POS_ONE},
    '{64'h8000_0000_0000_0001, 1'b0, 64'h0},
    '{$realtobits(1.0),       1'b0, 64'h0},
    '{$realtobits(-1.0),      1'b0, 64'h0},
    '{$realtobits(0.34657359027997264), 1'b0, 64'h0},
    '{$realtobits(709.78),    1'b0, 64'h0},
    '{$realtobits(709.8),     1'b0, 64'h0},
    '{$realtobits(-708.4),    1'b0, 64'h0},
    '{$realtobits(-740.0),    1'b0, 64'h0},
    '{$realtobits(-745.13),   1'b0, 64'h0},
    '{$realtobits(-1.0e-10),  1'b0, 64'h0}
  };

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [63:0] x_bits, result_bits;

  double_exp_unit_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .x_bits(x_bits),
    .out_valid(out_valid), .out_stall(out_stall), .result_bits(result_bits)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // pending results and the arguments they came from
  logic [63:0] exp_q[$];
  logic [63:0] arg_q[$];
  int     sent_cnt, mism_cnt;
  longint cyc;
  int     tx_idle_pct, rx_stall_pct;
  bit     cur_fixed;
  logic [63:0] cur_res;

  // truncating split of y into integer part and same-signed fraction
  function automatic void trunc_split(input real y, output real ip, output real fr);
    logic [63:0] b, m;
    int unsigned e;
    b = $realtobits(y);
    e = 32'(b[62:52]);
    if (e >= 1075) begin
      ip = y;
      fr = $bitstoreal({b[63], 63'h0});
    end else if (e < 1023) begin
      ip = $bitstoreal({b[63], 63'h0});
      fr = y;
    end else begin
      m  = 64'h000F_FFFF_FFFF_FFFF >> (e - 1023);
      ip = $bitstoreal(b & ~m);
      fr = y - ip;
    end
  endfunction

  // v * 2^n with a single final rounding
  function automatic real pow2_scale(input real v, input longint n);
    real big, tiny;
    big  = $bitstoreal(64'(2046) << 52);
    tiny = $bitstoreal(64'(54) << 52);
    if (n > 1023) begin
      v = v * big; n -= 1023;
      if (n > 1023) begin
        v = v * big; n -= 1023;
        if (n > 1023) n = 1023;
      end
    end else if (n < -1022) begin
      v = v * tiny; n += 969;
      if (n < -1022) begin
        v = v * tiny; n += 969;
        if (n < -1022) n = -1022;
      end
    end
    return v * $bitstoreal(64'(n + 1023) << 52);
  endfunction

  function automatic logic [63:0] exp_predict(input logic [63:0] xb);
    real ip, fr, z, p;
    int  k;
    if (xb[62:52] == EXP_ALL_ONES && xb[51:0] != 52'h0) return xb | QUIET_BIT;
    trunc_split($bitstoreal(xb) * $bitstoreal(LOG2E_BITS), ip, fr);
    if (fr > 0.5) begin
      ip = ip + 1.0; fr = fr - 1.0;
    end else if (fr < -0.5) begin
      ip = ip - 1.0; fr = fr + 1.0;
    end
    if (ip < -2147483648.0) return 64'h0;
    if (ip > 2147483647.0) ip = 2147483647.0;
    // Horner, highest coefficient first
    z = fr * $bitstoreal(LN2_BITS);
    k = NUM_TERMS_DEF - 1;
    p = $bitstoreal(COEF_ROM[k]);
    while (k > 0) begin
      k--;
      p = p * z + $bitstoreal(COEF_ROM[k]);
    end
    return $realtobits(pow2_scale(p, longint'(ip)));
  endfunction

  // accepted input word -> expected result
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      exp_q.push_back(cur_fixed ? cur_res : exp_predict(x_bits));
      arg_q.push_back(x_bits);
      sent_cnt <= sent_cnt + 1;
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (exp_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10) $display("unexpected result %h", result_bits);
      end else begin
        if (result_bits !== exp_q[0]) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("mismatch x=%h expected %h actual %h", arg_q[0], exp_q[0], result_bits);
        end
        void'(exp_q.pop_front());
        void'(arg_q.pop_front());
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_stall <= (!rst && $urandom_range(99) < rx_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // drive one word, idling as configured; returns once it is accepted
  task automatic send_word(input logic [63:0] xv, input bit fixed, input logic [63:0] rv);
    int cnt0;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cnt0 = sent_cnt;
    in_valid  <= 1'b1;
    x_bits    <= xv;
    cur_fixed <= fixed;
    cur_res   <= rv;
    do @(negedge clk); while (sent_cnt == cnt0);
  endtask

  function automatic logic [63:0] rand_arg();
    int sel;
    real r;
    sel = $urandom_range(99);
    r = real'($urandom) / 4294967296.0;
    if (sel < 55) return $realtobits(r * 1500.0 - 750.0);         // normal range
    if (sel < 75) return {$urandom, $urandom};                      // any encoding
    if (sel < 83) return {1'($urandom), 11'($urandom_range(1023, 900)), 20'($urandom), 32'($urandom)};
    if (sel < 89) return $realtobits(700.0 + r * 12.0);             // overflow edge
    if (sel < 95) return $realtobits(-760.0 + r * 55.0);            // subnormal band
    return {1'($urandom), EXP_ALL_ONES, 20'($urandom), 32'($urandom)}; // inf / NaN
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1; in_valid = 1'b0; x_bits = 64'h0; out_stall = 1'b0;
    cur_fixed = 1'b0; cur_res = 64'h0;
    sent_cnt = 0; mism_cnt = 0; cyc = 0;
    tx_idle_pct = 12; rx_stall_pct = 48;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows
    foreach (dir_tab[i]) send_word(dir_tab[i].x, dir_tab[i].fixed, dir_tab[i].res);

    // random words in three idling phases; drain fully between phases
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct  = (ph == 0) ? 12 : (ph == 1) ? 48 : 0;
      rx_stall_pct = (ph == 0) ? 48 : (ph == 1) ? 12 : 0;
      for (int i = 0; i < RAND_WORDS / 3; i++) send_word(rand_arg(), 1'b0, 64'h0);
      wait_drained();
    end

    repeat (DRAIN_CYC) @(posedge clk);
    if (mism_cnt == 0 && exp_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
